[design/bcp_pkg.sv]
package bcp_pkg;

	localparam int IN_W   = 7;
	localparam int COEF_W = 61;

	typedef logic [IN_W-1:0]   in_val_t;
	typedef logic [COEF_W-1:0] coef_t;

endpackage

[design/binomial_coefficient_pascal.sv]
// Binomial coefficient n_total choose k_choose by Pascal's triangle. Each item
// builds the triangle rows in place in a single-port-read row memory, one cell
// addition per cycle, walking each row from column min(i,k) down to 1; the one
// read port of that memory sets the rate. An item with k of zero skips the rows;
// an item with k above n or n above MAX_N answers 0 without building them. One
// item is worked on at a time; a finished result waits in an output register
// while the next item is accepted and started.
module binomial_coefficient_pascal
	import bcp_pkg::*;
#(
	parameter int MAX_N = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [IN_W-1:0]     n_total,
	input  logic [IN_W-1:0]     k_choose,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [COEF_W-1:0]   coefficient
);

	localparam int DEPTH = MAX_N + 1;
	localparam int AW    = $clog2(DEPTH);
	localparam logic [AW-1:0] ONE_A  = AW'(1);
	localparam logic [AW-1:0] ZERO_A = '0;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_INIT   = 3'd1;
	localparam logic [2:0] S_RSTART = 3'd2;
	localparam logic [2:0] S_RFIRST = 3'd3;
	localparam logic [2:0] S_CELL   = 3'd4;
	localparam logic [2:0] S_FIN    = 3'd5;
	localparam logic [2:0] S_FLAT   = 3'd6;
	localparam logic [2:0] S_DONE   = 3'd7;

	logic [2:0]    state_q;
	logic [AW-1:0] n_q, k_q, i_q, j_q;
	coef_t         upper_q, res_q;
	logic          out_valid_q;
	coef_t         coefficient_q;

	logic          mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr;
	coef_t         mem_wdata, mem_rdata;
	logic [AW-1:0] top;
	logic          in_xfer, out_free, bad_item;

	bcp_row_mem #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_row_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	assign in_ready  = (state_q == S_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign bad_item  = (n_total > IN_W'(MAX_N)) || (k_choose > n_total);
	assign top       = (i_q < k_q) ? i_q : k_q;

	always_comb begin
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_waddr = j_q;
		mem_raddr = j_q;
		mem_wdata = '0;
		unique case (state_q)
			S_INIT: begin
				mem_we    = 1'b1;
				mem_wdata = (j_q == ZERO_A) ? COEF_W'(1) : '0;
			end
			S_RSTART: begin
				mem_re    = 1'b1;
				mem_raddr = top;
			end
			S_RFIRST: begin
				mem_re    = 1'b1;
				mem_raddr = j_q - ONE_A;
			end
			S_CELL: begin
				mem_we    = 1'b1;
				mem_waddr = j_q + ONE_A;
				mem_wdata = upper_q + mem_rdata;
				mem_re    = (j_q != ZERO_A);
				mem_raddr = j_q - ONE_A;
			end
			S_FIN: begin
				mem_re    = 1'b1;
				mem_raddr = k_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						state_q <= bad_item ? S_DONE : S_INIT;
					end
				end
				S_INIT: begin
					if (j_q == k_q) begin
						state_q <= (k_q == ZERO_A) ? S_FIN : S_RSTART;
					end
				end
				S_RSTART: state_q <= S_RFIRST;
				S_RFIRST: state_q <= S_CELL;
				S_CELL: begin
					if (j_q == ZERO_A) begin
						state_q <= (i_q == n_q) ? S_FIN : S_RSTART;
					end
				end
				S_FIN:  state_q <= S_FLAT;
				S_FLAT: state_q <= S_DONE;
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					n_q   <= n_total[AW-1:0];
					k_q   <= k_choose[AW-1:0];
					j_q   <= ZERO_A;
					res_q <= '0;
				end
			end
			S_INIT: begin
				j_q <= j_q + ONE_A;
				i_q <= ONE_A;
			end
			S_RSTART: j_q <= top;
			S_RFIRST: begin
				upper_q <= mem_rdata;
				j_q     <= j_q - ONE_A;
			end
			S_CELL: begin
				// hold the lower neighbour as the next cell's upper term
				upper_q <= mem_rdata;
				if (j_q == ZERO_A) begin
					i_q <= i_q + ONE_A;
				end else begin
					j_q <= j_q - ONE_A;
				end
			end
			S_FLAT: res_q <= mem_rdata;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			coefficient_q <= res_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign coefficient = coefficient_q;

	a_write_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> mem_waddr <= k_q)
		else $error("row write beyond column k");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && mem_re) |-> mem_raddr != mem_waddr)
		else $error("read and write of the same row entry in one cycle");

	a_bad_item_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && bad_item) |=> (state_q == S_DONE && res_q == '0))
		else $error("out-of-range item not answered with zero");

	a_done_loads_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_free) |=> (out_valid && coefficient == $past(res_q)))
		else $error("finished result not transferred to output register");

endmodule

[design/bcp_row_mem.sv]
module bcp_row_mem
	import bcp_pkg::*;
#(
	parameter int DEPTH = 65,
	parameter int AW    = 7
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  coef_t         wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output coef_t         rdata
);

	coef_t mem_q [DEPTH];
	coef_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[sim/binomial_coefficient_pascal_test.sv]
module binomial_coefficient_pascal_test
	import bcp_pkg::*;
();

	localparam int MAX_N       = 64;
	localparam int CYCLE_LIMIT = 3_000_000;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              in_valid  = 1'b0;
	logic              in_ready;
	in_val_t           n_total   = '0;
	in_val_t           k_choose  = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	coef_t             coefficient;

	coef_t             expected_coefs[$];
	int                mismatches = 0;
	int                cycles     = 0;
	int                stall_left = 0;
	// no idling on either side while set
	logic              steady     = 1'b0;

	binomial_coefficient_pascal #(.MAX_N(MAX_N)) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.n_total     (n_total),
		.k_choose    (k_choose),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.coefficient (coefficient)
	);

	always #1 clk = ~clk;

	// Build the triangle rows in place, high column first, as the block does.
	function automatic coef_t pascal_choose(input int unsigned n, input int unsigned k);
		logic [63:0] row [0:MAX_N];
		int unsigned top;
		if (n > MAX_N || k > n)
			return '0;
		row[0] = 64'd1;
		for (int unsigned j = 1; j <= k; j++)
			row[j] = 64'd0;
		for (int unsigned i = 1; i <= n; i++) begin
			top = (i < k) ? i : k;
			for (int j = top; j >= 1; j--)
				row[j] = row[j] + row[j-1];
		end
		return row[k][COEF_W-1:0];
	endfunction

	// Mostly short gaps, now and then a long one.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (steady || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	// Present one pair and hold it until the transfer.
	task automatic send_pair(input int unsigned n, input int unsigned k);
		int unsigned gap;
		gap = pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		n_total  <= in_val_t'(n);
		k_choose <= in_val_t'(k);
		do @(posedge clk); while (!in_ready);
		expected_coefs.push_back(pascal_choose(n, k));
	endtask

	task automatic test_edge_pairs();
		send_pair(0, 0);
		send_pair(1, 0);
		send_pair(1, 1);
		send_pair(2, 1);
		send_pair(5, 3);
		send_pair(64, 0);
		send_pair(64, 1);
		send_pair(64, 32);
		send_pair(64, 63);
		send_pair(64, 64);
		send_pair(63, 31);
		send_pair(62, 31);
	endtask

	// k above n and n above the largest row both answer zero; the last pair is in range.
	task automatic test_out_of_range();
		send_pair(0, 1);
		send_pair(3, 5);
		send_pair(64, 65);
		send_pair(0, 127);
		send_pair(65, 0);
		send_pair(65, 65);
		send_pair(100, 3);
		send_pair(127, 127);
		send_pair(4, 2);
	endtask

	task automatic test_random_pairs();
		int unsigned r;
		int unsigned n;
		int unsigned k;
		for (int idx = 0; idx < 260; idx++) begin
			steady = ((idx / 30) % 4) == 3;
			r = $urandom_range(0, 99);
			if (r < 60) begin
				n = $urandom_range(0, 20);
				k = $urandom_range(0, n);
			end else if (r < 72) begin
				n = $urandom_range(21, MAX_N);
				k = $urandom_range(0, n);
			end else if (r < 82) begin
				n = $urandom_range(0, MAX_N - 1);
				k = $urandom_range(n + 1, 127);
			end else if (r < 90) begin
				n = $urandom_range(MAX_N + 1, 127);
				k = $urandom_range(0, 127);
			end else begin
				n = $urandom_range(0, 127);
				k = $urandom_range(0, 127);
			end
			send_pair(n, k);
		end
		steady = 1'b0;
	endtask

	// Receiver: random stalls, none while steady.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			out_ready  <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!steady && $urandom_range(0, 99) < 20) begin
			out_ready  <= 1'b0;
			stall_left <= pick_gap();
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_coefs.size() == 0) begin
				$error("coefficient: no result expected, got %0d", coefficient);
				mismatches++;
			end else begin
				coef_t want;
				want = expected_coefs.pop_front();
				if (coefficient !== want) begin
					$error("coefficient: expected %0d, actual %0d", want, coefficient);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_edge_pairs();
		test_out_of_range();
		test_random_pairs();
		in_valid <= 1'b0;
		while (expected_coefs.size() != 0)
			@(posedge clk);
		// let any stray result show up
		repeat (50) @(posedge clk);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

[binomial_coefficient_pascal.f]
design/bcp_pkg.sv
design/bcp_row_mem.sv
design/binomial_coefficient_pascal.sv
sim/binomial_coefficient_pascal_test.sv
